FILE: rtl/tmps_pkg.sv
// Shared types and constants for the number-triangle max path sum block.
// No dependencies; imported by the controller, datapath and top level.
package tmps_pkg;

  // Width of the row_count register field and of the reported path total
  localparam int CFG_W   = 7;
  localparam int TOTAL_W = 22;

  // Register index decoded from paddr[2]
  localparam logic REG_ROW_COUNT = 1'b0;

  // Commands from the controller to the datapath, at most one high per cycle
  typedef struct packed {
    logic load;      // store the accepted element
    logic init_rd;   // read bottom-row element j
    logic init_wr;   // copy it into best sum j
    logic row_rd;    // read best sum 1 at the start of a row
    logic row_prev;  // capture best sum 1 as the running left value
    logic cell_rd;   // read element (i,j) and best sum j+1
    logic cell_wr;   // pick, add, write best sum j and choice (i,j)
    logic path_rd;   // read element and choice on the path at row i
    logic path_out;  // present one path result, step to the next row
  } cmd_t;

  // Status from the datapath counters back to the controller
  typedef struct packed {
    logic load_last;  // element being loaded is the last of the triangle
    logic init_end;   // bottom-row copy reached the last column
    logic init_solo;  // triangle has a single row
    logic j_end;      // column counter reached the end of row i
    logic i_one;      // current row is the apex row
    logic path_end;   // path walk is at the bottom row
  } sts_t;

endpackage

FILE: rtl/tmps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the element, choice and best-sum stores.
module tmps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/tmps_ctrl.sv
// Sequencer for load, bottom-up sweep and path walk of the triangle block.
// Depends on tmps_pkg for the command and status structs.
module tmps_ctrl import tmps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT_RD,
    ST_INIT_WR,
    ST_ROW_RD,
    ST_ROW_PREV,
    ST_CELL_RD,
    ST_CELL_WR,
    ST_PATH_RD,
    ST_PATH_OUT
  } state_t;

  state_t state;
  state_t state_next;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start && sts.load_last) begin
          state_next = ST_INIT_RD;
        end
      end
      ST_INIT_RD:  state_next = ST_INIT_WR;
      ST_INIT_WR: begin
        if (!sts.init_end) begin
          state_next = ST_INIT_RD;
        end else if (sts.init_solo) begin
          state_next = ST_PATH_RD;
        end else begin
          state_next = ST_ROW_RD;
        end
      end
      ST_ROW_RD:   state_next = ST_ROW_PREV;
      ST_ROW_PREV: state_next = ST_CELL_RD;
      ST_CELL_RD:  state_next = ST_CELL_WR;
      ST_CELL_WR: begin
        if (!sts.j_end) begin
          state_next = ST_CELL_RD;
        end else if (sts.i_one) begin
          state_next = ST_PATH_RD;
        end else begin
          state_next = ST_ROW_RD;
        end
      end
      ST_PATH_RD:  state_next = ST_PATH_OUT;
      ST_PATH_OUT: state_next = sts.path_end ? ST_IDLE : ST_PATH_RD;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Command decode
  always_comb begin
    cmd          = '0;
    cmd.load     = (state == ST_IDLE) && start;
    cmd.init_rd  = (state == ST_INIT_RD);
    cmd.init_wr  = (state == ST_INIT_WR);
    cmd.row_rd   = (state == ST_ROW_RD);
    cmd.row_prev = (state == ST_ROW_PREV);
    cmd.cell_rd  = (state == ST_CELL_RD);
    cmd.cell_wr  = (state == ST_CELL_WR);
    cmd.path_rd  = (state == ST_PATH_RD);
    cmd.path_out = (state == ST_PATH_OUT);
  end

  // State and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != ST_IDLE);
    end
  end

endmodule

FILE: rtl/tmps_datapath.sv
// Counters, stores and arithmetic of the triangle max path sum block.
// Depends on tmps_pkg and tmps_ram.
module tmps_datapath import tmps_pkg::*; #(
  parameter int MAX_ROWS     = 64,
  parameter int ELEMENT_BITS = 16,
  parameter int COL_W        = $clog2(MAX_ROWS + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cmd_t                           cmd,
  output sts_t                           sts,
  input  logic                           cfg_we,
  input  logic [CFG_W-1:0]               cfg_data,
  output logic [COL_W-1:0]               rows,
  input  logic signed [ELEMENT_BITS-1:0] element_value,
  output logic                           result_valid,
  output logic signed [ELEMENT_BITS-1:0] path_value,
  output logic [COL_W-1:0]               path_column,
  output logic signed [TOTAL_W-1:0]      best_total,
  output logic                           last
);

  localparam int CELLS  = MAX_ROWS * MAX_ROWS;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int BA_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SUM_W  = ELEMENT_BITS + $clog2(MAX_ROWS) + 1;
  localparam int EXT_W  = (SUM_W > TOTAL_W) ? SUM_W : TOTAL_W;

  // Flat store address of (row, column), both counted from one
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return ADDR_W'((int'(r) - 1) * MAX_ROWS + int'(c) - 1);
  endfunction

  logic [COL_W-1:0] load_row;
  logic [COL_W-1:0] load_column;
  logic [COL_W-1:0] i;
  logic [COL_W-1:0] j;
  logic [COL_W-1:0] idx;
  logic [COL_W-1:0] j_m1;
  logic signed [SUM_W-1:0] prev;
  logic signed [SUM_W-1:0] total;
  logic signed [EXT_W-1:0] total_ext;

  logic                    elem_we;
  logic [ADDR_W-1:0]       elem_waddr;
  logic [ADDR_W-1:0]       elem_raddr;
  logic [ELEMENT_BITS-1:0] elem_rdata;
  logic                    choice_wdata;
  logic                    choice_rdata;
  logic                    best_we;
  logic [BA_W-1:0]         best_waddr;
  logic [BA_W-1:0]         best_raddr;
  logic [SUM_W-1:0]        best_wdata;
  logic [SUM_W-1:0]        best_rdata;

  logic signed [SUM_W-1:0] elem_ext;
  logic signed [SUM_W-1:0] lower_right;
  logic                    take_down;
  logic signed [SUM_W-1:0] new_sum;
  logic [CFG_W-1:0]        cfg_rows;

  // Status
  assign sts.load_last = (load_column == load_row) && (load_row == rows);
  assign sts.init_end  = (j == rows);
  assign sts.init_solo = (rows == COL_W'(1));
  assign sts.j_end     = (j == i);
  assign sts.i_one     = (i == COL_W'(1));
  assign sts.path_end  = (i == rows);

  // Cell step: pick the larger lower sum, ties go down-right
  assign j_m1        = j - COL_W'(1);
  assign elem_ext    = SUM_W'($signed(elem_rdata));
  assign lower_right = $signed(best_rdata);
  assign take_down   = prev > lower_right;
  assign new_sum     = (take_down ? prev : lower_right) + elem_ext;
  assign choice_wdata = !take_down;

  // Store addressing
  assign elem_we    = cmd.load;
  assign elem_waddr = cell_addr(load_row, load_column);
  always_comb begin
    if (cmd.init_rd) begin
      elem_raddr = cell_addr(rows, j);
    end else if (cmd.path_rd) begin
      elem_raddr = cell_addr(i, idx);
    end else begin
      elem_raddr = cell_addr(i, j);
    end
  end

  assign best_we    = cmd.init_wr || cmd.cell_wr;
  assign best_waddr = BA_W'(j_m1);
  assign best_wdata = cmd.init_wr ? elem_ext : new_sum;
  assign best_raddr = cmd.row_rd ? '0 : BA_W'(j);

  // Configuration value: zero reads as one, saturate at the store size
  assign cfg_rows = (cfg_data == '0) ? CFG_W'(1) : cfg_data;

  // Control counters and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      rows         <= COL_W'(1);
      load_row     <= COL_W'(1);
      load_column  <= COL_W'(1);
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.path_out;
      if (cfg_we) begin
        if (int'(cfg_rows) > MAX_ROWS) begin
          rows <= COL_W'(MAX_ROWS);
        end else begin
          rows <= COL_W'(cfg_rows);
        end
        load_row    <= COL_W'(1);
        load_column <= COL_W'(1);
      end else if (cmd.load) begin
        if (sts.load_last) begin
          load_row    <= COL_W'(1);
          load_column <= COL_W'(1);
        end else if (load_column == load_row) begin
          load_row    <= load_row + COL_W'(1);
          load_column <= COL_W'(1);
        end else begin
          load_column <= load_column + COL_W'(1);
        end
      end
    end
  end

  // Sweep and path counters, running sums, result registers
  always_ff @(posedge clk) begin
    if (cmd.load && sts.load_last) begin
      j   <= COL_W'(1);
      i   <= rows - COL_W'(1);
      idx <= COL_W'(1);
    end
    if (cmd.init_wr) begin
      if (sts.init_end) begin
        j <= COL_W'(1);
        if (sts.init_solo) begin
          i <= COL_W'(1);
        end
      end else begin
        j <= j + COL_W'(1);
      end
    end
    if (cmd.row_prev) begin
      prev <= $signed(best_rdata);
    end
    if (cmd.cell_wr) begin
      prev <= lower_right;
      if (sts.j_end) begin
        j <= COL_W'(1);
        if (!sts.i_one) begin
          i <= i - COL_W'(1);
        end
      end else begin
        j <= j + COL_W'(1);
      end
    end
    if (best_we && (j == COL_W'(1))) begin
      total <= $signed(best_wdata);
    end
    if (cmd.path_out) begin
      path_value  <= $signed(elem_rdata);
      path_column <= idx;
      best_total  <= total_ext[TOTAL_W-1:0];
      last        <= sts.path_end;
      if (!sts.path_end) begin
        i   <= i + COL_W'(1);
        idx <= idx + COL_W'(choice_rdata);
      end
    end
  end

  assign total_ext = EXT_W'(total);

  // Stores
  tmps_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(CELLS)) u_elem_ram (
    .clk   (clk),
    .we    (elem_we),
    .waddr (elem_waddr),
    .wdata (element_value),
    .raddr (elem_raddr),
    .rdata (elem_rdata)
  );

  tmps_ram #(.WIDTH(1), .DEPTH(CELLS)) u_choice_ram (
    .clk   (clk),
    .we    (cmd.cell_wr),
    .waddr (cell_addr(i, j)),
    .wdata (choice_wdata),
    .raddr (cell_addr(i, idx)),
    .rdata (choice_rdata)
  );

  tmps_ram #(.WIDTH(SUM_W), .DEPTH(MAX_ROWS)) u_best_ram (
    .clk   (clk),
    .we    (best_we),
    .waddr (best_waddr),
    .wdata (best_wdata),
    .raddr (best_raddr),
    .rdata (best_rdata)
  );

endmodule

FILE: rtl/triangle_max_path_sum.sv
// Top level of the number-triangle maximal path sum block.
// Depends on tmps_pkg, tmps_ctrl, tmps_datapath (and tmps_ram below it).
//
//  channel   | handshake                         | payload
//  ----------+-----------------------------------+-----------------------------------
//  element   | start & !busy                     | element_value
//  result    | result_valid (one cycle strobe)   | path_value, path_column,
//            |                                   | best_total, last
//  config    | psel & penable & pwrite (pready=1)| paddr, pwdata -> row_count
//
// Elements load one per cycle while busy is low. The transfer of the last
// element starts the solve; each store access step is a read state and then
// a write or capture state, set by the single read port of the element and
// best-sum memories. Path results never come back to back; busy drops with the
// strobe of the bottom-row result. The receiver cannot stall results.
// Reset restores row_count to one and the load position to row one, column one.
module triangle_max_path_sum import tmps_pkg::*; #(
  parameter int MAX_ROWS     = 64,
  parameter int ELEMENT_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [ELEMENT_BITS-1:0]        element_value,
  output logic                                  result_valid,
  output logic signed [ELEMENT_BITS-1:0]        path_value,
  output logic [$clog2(MAX_ROWS + 1)-1:0]       path_column,
  output logic signed [TOTAL_W-1:0]             best_total,
  output logic                                  last,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [2:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  localparam int COL_W = $clog2(MAX_ROWS + 1);

  cmd_t             cmd;
  sts_t             sts;
  logic             cfg_we;
  logic [COL_W-1:0] rows;

  // Register port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_ROW_COUNT);
  assign prdata = (paddr[2] == REG_ROW_COUNT) ? 32'(rows) : '0;

  tmps_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  tmps_datapath #(
    .MAX_ROWS     (MAX_ROWS),
    .ELEMENT_BITS (ELEMENT_BITS),
    .COL_W        (COL_W)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_data      (pwdata[CFG_W-1:0]),
    .rows          (rows),
    .element_value (element_value),
    .result_valid  (result_valid),
    .path_value    (path_value),
    .path_column   (path_column),
    .best_total    (best_total),
    .last          (last)
  );

  // Bottom-row result ends the solve; earlier results come while busy
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (last == !busy))
    else $error("last result and busy flag disagree");

  // Result strobes are never back to back
  a_strobe_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("consecutive result strobes");

  // Solve starts only from an element transfer
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an element transfer");

endmodule
